FILE: rtl/scma_pkg.sv
package scma_pkg;

   localparam int NUM_CHAN = 6;
   localparam int CHAN_W = 3;
   localparam int CFG_W = 5;
   localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd10;
   localparam logic [CHAN_W-1:0] LAST_CHAN = 3'd5;

   // request to the running-sum store
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic              clr;
      logic [CHAN_W-1:0] idx;
   } sum_ctl_type;

endpackage

FILE: rtl/six_channel_moving_average.sv
// An accepted req word passes S_RING, then S_SUM_RD, S_SUM_UPD and S_DIV for
//   each channel in turn, then S_DONE. SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) + 1.
// One word is in work at a time: req stays closed until S_DONE, which waits while rsp
//   stalls. The shared serial divider takes one quotient bit a cycle per channel.
// Reset: synchronous, active high; window back to 10, filter emptied,
//   output register invalid. The sample ring itself is not cleared.
module six_channel_moving_average #(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // req_tdata, lowest bit up: roll_in, pitch_in, yaw_in,
   //   accel_x_in, accel_y_in, accel_z_in, zero pad to whole bytes
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]         req_tdata,
   // rsp_tdata, lowest bit up: roll_avg, pitch_avg, yaw_avg,
   //   accel_x_avg, accel_y_avg, accel_z_avg, zero pad to whole bytes
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [((6*SAMPLE_BITS+7)/8)*8-1:0]         rsp_tdata,
   // window_length register
   input  logic                                       csr_wr_en,
   input  logic [scma_pkg::CFG_W-1:0]                 csr_wr_data
);
   import scma_pkg::*;

   localparam int TDATA_W = ((NUM_CHAN*SAMPLE_BITS+7)/8)*8;
   localparam int ROW_W   = NUM_CHAN*SAMPLE_BITS;
   localparam int SLOT_W  = $clog2(MAX_WINDOW);
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RING,
      S_SUM_RD,
      S_SUM_UPD,
      S_DIV,
      S_DONE
   } state_type;

   state_type          state_ff;
   logic [CFG_W-1:0]   win_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_new_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  oldest_ff;
   logic               full_ff;
   logic [ROW_W-1:0]   sample_ff;
   logic [ROW_W-1:0]   avg_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic               rsp_valid_ff;
   logic [ROW_W-1:0]   rsp_data_ff;

   logic [CNT_W-1:0]        eff_win;
   logic [CNT_W:0]          oldest_sum;
   logic [CNT_W:0]          oldest_in;
   logic                    full_in;
   logic                    out_free;
   logic [SLOT_W-1:0]       slot_in;

   logic [ROW_W-1:0]        ring_rd_data;
   logic                    ring_wr;
   logic                    ring_rd;
   sum_ctl_type             sum_ctl;
   logic signed [SUM_W-1:0] sum_rd;
   logic signed [SUM_W-1:0] sum_new;
   logic signed [SAMPLE_BITS-1:0] new_smp;
   logic signed [SAMPLE_BITS-1:0] old_smp;
   logic                    div_start;
   logic                    div_done;
   logic [SAMPLE_BITS-1:0]  div_quo;

   // window clamped to 1..MAX_WINDOW
   always_comb begin
      if (win_ff == '0) begin
         eff_win = CNT_W'(1);
      end else if (32'(win_ff) > MAX_WINDOW) begin
         eff_win = CNT_W'(MAX_WINDOW);
      end else begin
         eff_win = CNT_W'(win_ff);
      end
   end

   // oldest slot = (slot - window) mod MAX_WINDOW; sum stays below 2*MAX_WINDOW
   assign full_in    = fill_ff >= eff_win;
   assign oldest_sum = (CNT_W+1)'(slot_ff) + (CNT_W+1)'(MAX_WINDOW)
                       - (CNT_W+1)'(eff_win);
   assign oldest_in  = (oldest_sum >= (CNT_W+1)'(MAX_WINDOW))
                       ? oldest_sum - (CNT_W+1)'(MAX_WINDOW) : oldest_sum;
   assign slot_in    = (slot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

   // channel lanes for the sum update
   assign new_smp = sample_ff[chan_ff*SAMPLE_BITS +: SAMPLE_BITS];
   assign old_smp = ring_rd_data[chan_ff*SAMPLE_BITS +: SAMPLE_BITS];
   assign sum_new = sum_rd + SUM_W'(new_smp) - (full_ff ? SUM_W'(old_smp) : '0);

   assign ring_rd     = (state_ff == S_RING);
   assign ring_wr     = (state_ff == S_DONE) && out_free;
   assign div_start   = (state_ff == S_SUM_UPD);
   assign sum_ctl.rd  = (state_ff == S_SUM_RD);
   assign sum_ctl.wr  = (state_ff == S_SUM_UPD);
   assign sum_ctl.clr = csr_wr_en;
   assign sum_ctl.idx = chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_ff       <= WINDOW_RESET;
         fill_ff      <= '0;
         slot_ff      <= '0;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            // any window write empties the filter
            win_ff  <= csr_wr_data;
            fill_ff <= '0;
            slot_ff <= '0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  sample_ff   <= req_tdata[ROW_W-1:0];
                  full_ff     <= full_in;
                  oldest_ff   <= SLOT_W'(oldest_in);
                  fill_new_ff <= full_in ? fill_ff : fill_ff + 1'b1;
                  chan_ff     <= '0;
                  state_ff    <= S_RING;
               end
            end
            S_RING: begin
               state_ff <= S_SUM_RD;
            end
            S_SUM_RD: begin
               state_ff <= S_SUM_UPD;
            end
            S_SUM_UPD: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  avg_ff[chan_ff*SAMPLE_BITS +: SAMPLE_BITS] <= div_quo;
                  if (chan_ff == LAST_CHAN) begin
                     state_ff <= S_DONE;
                  end else begin
                     chan_ff  <= chan_ff + 1'b1;
                     state_ff <= S_SUM_RD;
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_data_ff  <= avg_ff;
                  rsp_valid_ff <= 1'b1;
                  fill_ff      <= fill_new_ff;
                  slot_ff      <= slot_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   scma_ring #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (ROW_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (ring_rd),
      .rd_addr (oldest_ff),
      .rd_data (ring_rd_data)
   );

   scma_sums #(
      .SUM_W (SUM_W)
   ) u_sums (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sum_ctl),
      .wr_data (sum_new),
      .rd_data (sum_rd)
   );

   scma_div #(
      .SUM_W (SUM_W),
      .DIV_W (CNT_W),
      .QUO_W (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (fill_new_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

endmodule

FILE: rtl/scma_ring.sv
module scma_ring #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/scma_sums.sv
module scma_sums #(
   parameter int SUM_W = 21
) (
   input  logic                     clock,
   input  logic                     reset,
   input  scma_pkg::sum_ctl_type    ctl,
   input  logic signed [SUM_W-1:0]  wr_data,
   output logic signed [SUM_W-1:0]  rd_data
);
   import scma_pkg::*;

   logic signed [SUM_W-1:0] mem_ff [NUM_CHAN];
   logic [NUM_CHAN-1:0]     vld_ff;
   logic signed [SUM_W-1:0] rd_data_ff;
   logic                    rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem_ff[ctl.idx] <= wr_data;
      end
      if (ctl.rd) begin
         rd_data_ff <= mem_ff[ctl.idx];
      end
   end

   // entries not yet written since reset or a window change read as zero
   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr) begin
            vld_ff[ctl.idx] <= 1'b1;
         end
         if (ctl.rd) begin
            rd_vld_ff <= vld_ff[ctl.idx];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/scma_div.sv
module scma_div #(
   parameter int SUM_W = 21,
   parameter int DIV_W = 5,
   parameter int QUO_W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0]        divisor,
   output logic                    done,
   output logic [QUO_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             neg_ff;
   logic             done_ff;

   logic [DIV_W:0]   trial;
   logic             ge;
   logic [DIV_W-1:0] rem_in;
   logic [SUM_W-1:0] signed_quo;

   // restoring division on the magnitude, one quotient bit a cycle
   assign trial  = {rem_ff, quo_ff[SUM_W-1]};
   assign ge     = trial >= {1'b0, div_ff};
   assign rem_in = ge ? DIV_W'(trial - {1'b0, div_ff}) : DIV_W'(trial);

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         neg_ff <= dividend[SUM_W-1];
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[SUM_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // sign restored afterwards: truncation toward zero
   assign signed_quo = neg_ff ? SUM_W'(-quo_ff) : quo_ff;
   assign quotient   = signed_quo[QUO_W-1:0];
   assign done       = done_ff;

endmodule

FILE: rtl/scma_checker.sv
module scma_port_checks #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((6*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata
);

   // reset leaves no word pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word pending after reset");

   // one word in flight: input closed the cycle after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req accepted while a word is in work");

   // a fresh result is only produced while the input side is closed
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("rsp word appeared without work in progress");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled rsp word changed");

endmodule

bind six_channel_moving_average scma_port_checks #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_scma_port_checks (.*);

FILE: tb/scma_checker.sv
`timescale 1ns / 100ps

// Watches the req, rsp and csr ports, keeps its own boxcar state and checks
// every rsp word against the oldest predicted set of averages.
module scma_checker #(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 16,
   parameter int DATA_W      = 96
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [DATA_W-1:0]            req_tdata,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [DATA_W-1:0]            rsp_tdata,
   input  logic                         csr_wr_en,
   input  logic [scma_pkg::CFG_W-1:0]   csr_wr_data,
   output int                           mismatch_total,
   output int                           open_words
);
   import scma_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   sample_type       history [MAX_WINDOW][NUM_CHAN];
   longint           chan_sum [NUM_CHAN];
   int unsigned      held;
   int unsigned      next_slot;
   logic [CFG_W-1:0] window_reg;
   logic [DATA_W-1:0] avg_queue [$];

   function automatic string chan_name(input int c);
      case (c)
         0: return "roll";
         1: return "pitch";
         2: return "yaw";
         3: return "accel_x";
         4: return "accel_y";
         default: return "accel_z";
      endcase
   endfunction

   function automatic void empty_filter();
      for (int c = 0; c < NUM_CHAN; c++) chan_sum[c] = 0;
      held      = 0;
      next_slot = 0;
   endfunction

   // push one sample set, return the six truncated means
   function automatic logic [DATA_W-1:0] boxcar_update(input logic [DATA_W-1:0] word);
      int unsigned       span;
      int unsigned       slot;
      int unsigned       oldest;
      bit                full;
      sample_type        s;
      longint            q;
      logic [DATA_W-1:0] avg;
      if (window_reg == 0)
         span = 1;
      else if (window_reg > MAX_WINDOW)
         span = MAX_WINDOW;
      else
         span = window_reg;
      slot   = next_slot;
      full   = (held >= span);
      oldest = (slot + MAX_WINDOW - span) % MAX_WINDOW;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s = word[c*SAMPLE_BITS +: SAMPLE_BITS];
         if (full) chan_sum[c] -= history[oldest][c];
         chan_sum[c] += s;
         history[slot][c] = s;
      end
      if (!full) held++;
      next_slot = (slot + 1) % MAX_WINDOW;
      avg = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         q = chan_sum[c] / longint'(held);   // truncates toward zero
         avg[c*SAMPLE_BITS +: SAMPLE_BITS] = q[SAMPLE_BITS-1:0];
      end
      return avg;
   endfunction

   task automatic flag(input string msg);
      if (mismatch_total < 10) $display("%s", msg);
      mismatch_total++;
   endtask

   initial begin
      mismatch_total = 0;
      open_words     = 0;
   end

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      logic [SAMPLE_BITS-1:0] exp_f;
      logic [SAMPLE_BITS-1:0] got_f;
      if (reset) begin
         window_reg = WINDOW_RESET;
         empty_filter();
         avg_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (avg_queue.size() == 0) begin
               flag($sformatf("%0t: rsp word %h with nothing pending", $realtime, rsp_tdata));
            end else begin
               want = avg_queue.pop_front();
               for (int c = 0; c < NUM_CHAN; c++) begin
                  exp_f = want[c*SAMPLE_BITS +: SAMPLE_BITS];
                  got_f = rsp_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
                  if (got_f !== exp_f)
                     flag($sformatf("%0t: %s_avg expected %0d got %0d (%h)", $realtime,
                                    chan_name(c), $signed(exp_f), $signed(got_f), got_f));
               end
            end
         end
         if (csr_wr_en) begin
            window_reg = csr_wr_data;
            empty_filter();
         end
         if (req_tvalid && req_tready) avg_queue = {avg_queue, boxcar_update(req_tdata)};
      end
      open_words = avg_queue.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the six-channel boxcar filter. The checker beside
// the block does all prediction; this module only drives words, window
// writes and back-pressure.
module tb_top;
   import scma_pkg::*;

   localparam int MAX_WINDOW   = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int DATA_W       = ((6*SAMPLE_BITS+7)/8)*8;
   localparam int RANDOM_WORDS = 830;
   localparam int LONG_HOLD    = 600;     // rsp held off this many cycles once
   localparam int DRAIN_CYCLES = 160;     // idle time after the last word has come back
   localparam int HOLD_PHASE   = 2;
   localparam int DRAIN_PHASE  = 4;
   localparam longint TIMEOUT_NS = 64'd8_000_000;

   typedef enum {MIX_ANY, HOLD_HIGH, HOLD_LOW, CORNERS} level_mode_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic              csr_wr_en;
   logic [CFG_W-1:0]  csr_wr_data;
   int                mismatch_total;
   int                open_words;

   bit tail_phase;     // final stretch: no idling on either side
   bit sender_calm;    // sender makes no gaps this phase
   bit hold_request;   // set by stimulus, taken by the rsp side

   always #4 clock = ~clock;

   six_channel_moving_average #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   scma_checker #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .DATA_W      (DATA_W)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_total (mismatch_total),
      .open_words     (open_words)
   );

   // ---- sample construction -------------------------------------------

   function automatic logic [SAMPLE_BITS-1:0] corner_value();
      case ($urandom_range(0, 4))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'h0001;
      endcase
   endfunction

   // same value on all six channels
   function automatic logic [DATA_W-1:0] uniform_word(input logic [SAMPLE_BITS-1:0] v);
      logic [DATA_W-1:0] w;
      w = '0;
      for (int c = 0; c < NUM_CHAN; c++) w[c*SAMPLE_BITS +: SAMPLE_BITS] = v;
      return w;
   endfunction

   // each channel at a different extreme: max, min, -1, +1, zero, min+1
   function automatic logic [DATA_W-1:0] spread_word();
      logic [DATA_W-1:0] w;
      w = '0;
      w[0*SAMPLE_BITS +: SAMPLE_BITS] = 16'h7FFF;
      w[1*SAMPLE_BITS +: SAMPLE_BITS] = 16'h8000;
      w[2*SAMPLE_BITS +: SAMPLE_BITS] = 16'hFFFF;
      w[3*SAMPLE_BITS +: SAMPLE_BITS] = 16'h0001;
      w[4*SAMPLE_BITS +: SAMPLE_BITS] = 16'h0000;
      w[5*SAMPLE_BITS +: SAMPLE_BITS] = 16'h8001;
      return w;
   endfunction

   function automatic logic [DATA_W-1:0] make_word(input level_mode_type mode);
      logic [DATA_W-1:0]      w;
      logic [SAMPLE_BITS-1:0] v;
      w = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         case (mode)
            HOLD_HIGH: v = 16'h7FFF - 16'($urandom_range(0, 3));
            HOLD_LOW:  v = 16'h8000 + 16'($urandom_range(0, 3));
            CORNERS:   v = corner_value();
            default:   v = ($urandom_range(0, 7) == 0) ? corner_value()
                                                       : 16'($urandom);
         endcase
         w[c*SAMPLE_BITS +: SAMPLE_BITS] = v;
      end
      return w;
   endfunction

   // planned windows first (extremes, zero and oversize among them), then random
   function automatic logic [CFG_W-1:0] window_for_phase(input int p);
      case (p)
         0: return 5'd16;
         1: return 5'd31;
         2: return 5'd1;
         3: return 5'd17;
         4: return 5'd0;
         5: return 5'd5;
         6: return 5'd16;
         7: return 5'd3;
         8: return 5'd10;
         9: return 5'd15;
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   // ---- drivers ------------------------------------------------------

   // offer one word, keep tvalid high afterwards so back-to-back words stay
   // continuous; gaps lower it first
   task automatic offer_word(input logic [DATA_W-1:0] word);
      if (!tail_phase && !sender_calm && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tdata  = word;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // window writes only once every pending word has come back
   task automatic write_window(input logic [CFG_W-1:0] span);
      req_tvalid = 1'b0;
      wait (open_words == 0);
      @(negedge clock);
      csr_wr_data = span;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // ---- rsp side: random stall bursts, one long hold-off on request ----
   initial begin : rsp_side
      bit rx_calm;
      rx_calm    = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            // long hold: block fills up and has to stall req
            hold_request = 1'b0;
            rsp_tready   = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!tail_phase && !rx_calm && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
         if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
      end
   end

   // ---- stimulus and verdict -------------------------------------------
   initial begin : stimulus
      int               sent;
      int               phase;
      int               span_words;
      level_mode_type   mode;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      tail_phase   = 1'b0;
      sender_calm  = 1'b1;
      hold_request = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: reset window of 10, fill past full with max then min so
      // the oldest drops out and partial means truncate toward zero
      for (int i = 0; i < 6; i++) offer_word(uniform_word(16'h7FFF));
      for (int i = 0; i < 6; i++) offer_word(uniform_word(16'h8000));
      offer_word(spread_word());

      // zero window behaves as one
      write_window(5'd0);
      offer_word(spread_word());
      offer_word(uniform_word(16'h8000));
      offer_word(uniform_word(16'h7FFF));

      // window of two, then the same value rewritten: filter must empty
      write_window(5'd2);
      offer_word(uniform_word(16'h8000));
      offer_word(uniform_word(16'h8001));
      offer_word(uniform_word(16'h7FFF));
      write_window(5'd2);
      offer_word(spread_word());
      offer_word(uniform_word(16'hFFFF));
      offer_word(uniform_word(16'h0001));

      // random phases, each with its own window
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         span_words = $urandom_range(20, 90);
         if (RANDOM_WORDS - sent <= 90) begin
            span_words = RANDOM_WORDS - sent;
            tail_phase = 1'b1;
         end
         write_window(window_for_phase(phase));
         sender_calm = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 5))
            0: mode = HOLD_HIGH;
            1: mode = HOLD_LOW;
            2: mode = CORNERS;
            default: mode = MIX_ANY;
         endcase
         for (int i = 0; i < span_words; i++) begin
            if (phase == HOLD_PHASE && i == 0) begin
               sender_calm  = 1'b1;
               hold_request = 1'b1;
            end
            if (phase == DRAIN_PHASE && i == span_words / 2) begin
               // sender pauses mid-phase until everything has come back
               req_tvalid = 1'b0;
               wait (open_words == 0);
               @(negedge clock);
            end
            offer_word(make_word(mode));
            sent++;
         end
         phase++;
      end

      req_tvalid = 1'b0;
      wait (open_words == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_total == 0 && open_words == 0)
         $display("six_channel_moving_average regression: pass");
      else
         $display("six_channel_moving_average regression: fail");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("six_channel_moving_average regression: fail");
      $finish;
   end

endmodule

FILE: six_channel_moving_average.f
rtl/scma_pkg.sv
rtl/scma_ring.sv
rtl/scma_sums.sv
rtl/scma_div.sv
rtl/six_channel_moving_average.sv
rtl/scma_checker.sv
tb/scma_checker.sv
tb/tb_top.sv
